// ===== design/pexp_pkg.sv =====
package pexp_pkg;

    // Fixed field widths of the item and write channels.
    localparam int OPCODE_W     = 2;
    localparam int SLOT_W       = 8;
    localparam int COLOR_W      = 16;
    localparam int INDEX_W      = 8;
    localparam int LINE_OUT_W   = 8;
    localparam int COLUMN_OUT_W = 9;
    localparam int SRC_WIDTH_W  = 9;
    localparam int SRC_HEIGHT_W = 8;
    localparam int COUNT_W      = 9;
    localparam int JOB_COL_W    = 10;
    localparam int CMP_W        = 11;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 8'd1;

    localparam logic [SRC_WIDTH_W-1:0]  SOURCE_WIDTH_RESET  = 9'd320;
    localparam logic [SRC_HEIGHT_W-1:0] SOURCE_HEIGHT_RESET = 8'd240;
    localparam logic [COUNT_W-1:0]      LINE_MAX            = 9'd511;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OPCODE_W-1:0] {
        OP_PALETTE = 2'd0,
        OP_PIXEL   = 2'd1,
        OP_FRAME   = 2'd2
    } t_opcode;

    // One classified pixel: base line, base column, which of the four
    // (line, column) pairs land on screen, and the swapped colour.
    typedef struct packed {
        logic [COUNT_W-1:0]   line0;
        logic [JOB_COL_W-1:0] col0;
        logic [3:0]           mask;
        logic [COLOR_W-1:0]   color;
    } t_job;

endpackage

// ===== design/pexp_in_if.sv =====
interface pexp_in_if;
    logic                            valid;
    logic                            ready;
    logic [pexp_pkg::OPCODE_W-1:0]   opcode;
    logic [pexp_pkg::SLOT_W-1:0]     palette_slot;
    logic [pexp_pkg::COLOR_W-1:0]    palette_value;
    logic [pexp_pkg::INDEX_W-1:0]    pixel_index;

    modport source (output valid, opcode, palette_slot, palette_value, pixel_index,
                    input ready);
    modport sink   (input valid, opcode, palette_slot, palette_value, pixel_index,
                    output ready);
endinterface

// ===== design/pexp_out_if.sv =====
interface pexp_out_if;
    logic                                valid;
    logic                                ready;
    logic [pexp_pkg::LINE_OUT_W-1:0]     screen_line;
    logic [pexp_pkg::COLUMN_OUT_W-1:0]   screen_column;
    logic [pexp_pkg::COLOR_W-1:0]        pixel_color;
    logic                                last_write;

    modport source (output valid, screen_line, screen_column, pixel_color, last_write,
                    input ready);
    modport sink   (input valid, screen_line, screen_column, pixel_color, last_write,
                    output ready);
endinterface

// ===== design/pexp_cfg_if.sv =====
interface pexp_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pexp_pkg::CFG_INDEX_W-1:0]   index;
    logic [pexp_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/pexp_front.sv =====
module pexp_front #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    pexp_in_if.sink                             i_pix,
    input  logic [pexp_pkg::SRC_WIDTH_W-1:0]    i_source_width,
    input  logic [pexp_pkg::SRC_HEIGHT_W-1:0]   i_source_height,
    output logic                                o_job_valid,
    output pexp_pkg::t_job                      o_job,
    input  logic                                i_job_ready
);
    import pexp_pkg::*;

    localparam int                 AW      = $clog2(PALETTE_DEPTH);
    localparam logic [CMP_W-1:0]   W_LIM   = CMP_W'(SCREEN_WIDTH);
    localparam logic [CMP_W-1:0]   H_LIM   = CMP_W'(SCREEN_HEIGHT);
    localparam logic [SLOT_W:0]    PAL_LIM = (SLOT_W + 1)'(PALETTE_DEPTH);

    logic [COLOR_W-1:0]   r_palette [PALETTE_DEPTH];
    logic [COLOR_W-1:0]   r_rd_raw;
    logic                 r_rd_zero;
    logic                 r_job_valid;
    logic [COUNT_W-1:0]   r_job_line;
    logic [JOB_COL_W-1:0] r_job_col;
    logic [3:0]           r_job_mask;
    logic [COUNT_W-1:0]   r_src_col;
    logic [COUNT_W-1:0]   r_tgt_line;

    logic                 accept;
    logic                 push;
    t_opcode              op;
    logic                 hdouble;
    logic                 center;
    logic                 vdouble;
    logic [JOB_COL_W-1:0] offset;
    logic [JOB_COL_W-1:0] col0;
    logic                 line0_ok;
    logic                 line1_ok;
    logic                 col0_ok;
    logic                 col1_ok;
    logic [3:0]           mask;
    logic                 row_end;
    logic [COUNT_W:0]     line_sum;
    logic [COUNT_W-1:0]   n_src_col;
    logic [COUNT_W-1:0]   n_tgt_line;
    logic [COLOR_W-1:0]   color;

    assign op     = t_opcode'(i_pix.opcode);
    assign push   = r_job_valid && i_job_ready;
    assign i_pix.ready = !r_job_valid || i_job_ready;
    assign accept = i_pix.valid && i_pix.ready;

    // Mode decode and screen placement of the current source pixel.
    always_comb begin
        hdouble  = {1'b0, i_source_width, 1'b0} <= W_LIM;
        center   = !hdouble && ({2'b00, i_source_width} <= W_LIM);
        vdouble  = {2'b00, i_source_height, 1'b0} <= H_LIM;
        offset   = JOB_COL_W'((W_LIM - {2'b00, i_source_width}) >> 1);
        col0     = hdouble ? {r_src_col, 1'b0} : (offset + {1'b0, r_src_col});
        line0_ok = {2'b00, r_tgt_line} < H_LIM;
        line1_ok = vdouble && (({2'b00, r_tgt_line} + CMP_W'(1)) < H_LIM);
        col0_ok  = (hdouble || center) && ({1'b0, col0} < W_LIM);
        col1_ok  = hdouble && (({1'b0, col0} + CMP_W'(1)) < W_LIM);
        mask     = {line1_ok && col1_ok, line1_ok && col0_ok,
                    line0_ok && col1_ok, line0_ok && col0_ok};

        row_end  = ({1'b0, r_src_col} + (COUNT_W + 1)'(1)) >= {1'b0, i_source_width};
        line_sum = {1'b0, r_tgt_line} + (vdouble ? (COUNT_W + 1)'(2) : (COUNT_W + 1)'(1));
        if (row_end) begin
            n_src_col  = '0;
            n_tgt_line = (line_sum > {1'b0, LINE_MAX}) ? LINE_MAX : line_sum[COUNT_W-1:0];
        end else begin
            n_src_col  = r_src_col + COUNT_W'(1);
            n_tgt_line = r_tgt_line;
        end
    end

    // Palette memory: at most one write or one registered read per accepted item.
    always_ff @(posedge i_clk) begin
        if (accept && op == OP_PALETTE && ({1'b0, i_pix.palette_slot} < PAL_LIM)) begin
            r_palette[i_pix.palette_slot[AW-1:0]] <= i_pix.palette_value;
        end
        if (accept && op == OP_PIXEL) begin
            r_rd_raw  <= r_palette[i_pix.pixel_index[AW-1:0]];
            r_rd_zero <= {1'b0, i_pix.pixel_index} >= PAL_LIM;
            r_job_line <= r_tgt_line;
            r_job_col  <= col0;
            r_job_mask <= mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_src_col   <= '0;
            r_tgt_line  <= '0;
        end else begin
            if (accept) begin
                r_job_valid <= (op == OP_PIXEL) && (mask != 4'b0000);
                unique case (op)
                    OP_PIXEL: begin
                        r_src_col  <= n_src_col;
                        r_tgt_line <= n_tgt_line;
                    end
                    OP_FRAME: begin
                        r_src_col  <= '0;
                        r_tgt_line <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (push) begin
                r_job_valid <= 1'b0;
            end
        end
    end

    assign color = r_rd_zero ? '0 : {r_rd_raw[7:0], r_rd_raw[15:8]};

    assign o_job_valid = r_job_valid;
    assign o_job       = '{line0: r_job_line, col0: r_job_col, mask: r_job_mask,
                           color: color};

endmodule

// ===== design/pexp_queue.sv =====
module pexp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pexp_pkg::t_job   i_data,
    output logic             o_ready,
    output logic             o_valid,
    output pexp_pkg::t_job   o_data,
    input  logic             i_pop
);
    import pexp_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    assign o_ready = r_count < QUEUE_CW'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QUEUE_CW'(1);
                2'b01:   r_count <= r_count - QUEUE_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/pexp_back.sv =====
module pexp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  pexp_pkg::t_job   i_job,
    output logic             o_job_pop,
    pexp_out_if.source       o_wr
);
    import pexp_pkg::*;

    t_job                    r_cur;
    logic [3:0]              r_cur_mask;
    logic                    r_out_valid;
    logic [LINE_OUT_W-1:0]   r_line;
    logic [COLUMN_OUT_W-1:0] r_col;
    logic [COLOR_W-1:0]      r_color;
    logic                    r_last;

    logic                    can_emit;
    logic                    has_work;
    logic [1:0]              sel;
    logic [3:0]              remain;
    logic [COUNT_W-1:0]      line_sel;
    logic [JOB_COL_W-1:0]    col_sel;

    assign can_emit  = !r_out_valid || o_wr.ready;
    assign has_work  = r_cur_mask != 4'b0000;

    always_comb begin
        if (r_cur_mask[0]) begin
            sel = 2'd0;
        end else if (r_cur_mask[1]) begin
            sel = 2'd1;
        end else if (r_cur_mask[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
        remain   = r_cur_mask & ~(4'b0001 << sel);
        line_sel = sel[1] ? (r_cur.line0 + COUNT_W'(1)) : r_cur.line0;
        col_sel  = sel[0] ? (r_cur.col0 + JOB_COL_W'(1)) : r_cur.col0;
    end

    // The next job is taken as the last write of the current one goes out.
    assign o_job_pop = i_job_valid && (!has_work || (can_emit && remain == 4'b0000));

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_cur <= i_job;
        end
        if (can_emit && has_work) begin
            r_line  <= line_sel[LINE_OUT_W-1:0];
            r_col   <= col_sel[COLUMN_OUT_W-1:0];
            r_color <= r_cur.color;
            r_last  <= remain == 4'b0000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_mask  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_job_pop) begin
                r_cur_mask <= i_job.mask;
            end else if (can_emit && has_work) begin
                r_cur_mask <= remain;
            end
            if (can_emit) begin
                r_out_valid <= has_work;
            end
        end
    end

    assign o_wr.valid         = r_out_valid;
    assign o_wr.screen_line   = r_line;
    assign o_wr.screen_column = r_col;
    assign o_wr.pixel_color   = r_color;
    assign o_wr.last_write    = r_last;

endmodule

// ===== design/palette_expand_pixel_doubler.sv =====
// Palette expansion with optional 2x upscale, producing framebuffer writes.
// i_pix carries items: a palette write (slot and 16-bit colour), a source pixel
// (8-bit colour index) or a start of frame, which rewinds to screen line 0.
// o_wr carries framebuffer writes, each with line, column, byte-swapped
// colour, and a flag on the last write that a source pixel causes. A pixel
// gives up to four writes; palette, frame and unused items give none.
// i_cfg sets the source width (index 0) and height (index 1); it is always
// ready and should be written only while the block is idle.
// A pixel passes through the front's job register, the job queue, the back's
// current-job register and the output register before its first write is on o_wr.
// The single write port emits one write per cycle while the receiver is ready,
// so a pixel holds it for all of its writes, four when both axes are doubled;
// new items are taken every cycle while the queue has room.
// A four-entry job queue and the output register absorb a stalled receiver;
// i_pix.ready falls only when the queue and the front stage are both full.
// Reset clears the column and line counters, empties the queue and restores
// a 320 by 240 source; palette entries hold nothing until they are written.
module palette_expand_pixel_doubler #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pexp_in_if.sink     i_pix,
    pexp_cfg_if.sink    i_cfg,
    pexp_out_if.source  o_wr
);
    import pexp_pkg::*;

    logic [SRC_WIDTH_W-1:0]  r_source_width;
    logic [SRC_HEIGHT_W-1:0] r_source_height;

    logic job_valid;
    t_job job;
    logic job_ready;
    logic q_valid;
    t_job q_data;
    logic q_pop;

    // Configuration registers; writes to indexes beyond the list are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_width  <= SOURCE_WIDTH_RESET;
            r_source_height <= SOURCE_HEIGHT_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_SOURCE_WIDTH) begin
                r_source_width <= i_cfg.data[SRC_WIDTH_W-1:0];
            end else if (i_cfg.index == REG_SOURCE_HEIGHT) begin
                r_source_height <= i_cfg.data[SRC_HEIGHT_W-1:0];
            end
        end
    end

    // The front decodes each item, keeps the counters and reads the palette.
    pexp_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pix           (i_pix),
        .i_source_width  (r_source_width),
        .i_source_height (r_source_height),
        .o_job_valid     (job_valid),
        .o_job           (job),
        .i_job_ready     (job_ready)
    );

    pexp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (job),
        .o_ready (job_ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    // The back expands each job into its framebuffer writes, one per cycle while the receiver is ready.
    pexp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_data),
        .o_job_pop   (q_pop),
        .o_wr        (o_wr)
    );

`ifndef SYNTHESIS
    // Items other than pixels never place a job in the queue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready && i_pix.opcode != OP_PIXEL) |=> !job_valid)
        else $error("job raised by an item that is not a pixel");

    // A taken write that is not the last is followed at once by the next one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr.valid && o_wr.ready && !o_wr.last_write) |=> o_wr.valid)
        else $error("gap inside the writes of one pixel");

    // No write is offered in the cycle after reset.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_wr.valid)
        else $error("write offered straight after reset");
`endif

endmodule

// ===== tb/palette_expand_pixel_doubler_tb.sv =====
`timescale 1ns / 1ps

// Testbench for the palette expansion block with its optional 2x upscale.
// Items go in on i_pix. A palette write fills one colour slot, a source pixel
// is looked up and turned into framebuffer writes, and a start of frame
// rewinds to screen line 0. The bench keeps its own copy of the palette, the
// column and line counters and both source size registers. From these it works
// out every write that an accepted item should cause. The monitor compares each
// write on o_wr with the oldest one still due.
module palette_expand_pixel_doubler_tb;

    import pexp_pkg::*;

    localparam int SCREEN_W  = 320;
    localparam int SCREEN_H  = 240;
    localparam int PAL_DEPTH = 256;

    // The line counter stops at this value and never wraps back onto the screen.
    localparam int unsigned LINE_CAP = 511;

    // Settling time before a register write, and after the last write is seen.
    // The block is only a few stages deep, but a trailing pixel that lands off
    // screen gives no write that we could wait for.
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 100;

    // Opcode 3 has no name in the package. The block must simply ignore it.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [SLOT_W-1:0]   palette_slot;
        logic [COLOR_W-1:0]  palette_value;
        logic [INDEX_W-1:0]  pixel_index;
    } t_pix_item;

    typedef struct packed {
        logic [LINE_OUT_W-1:0]   scr_line;
        logic [COLUMN_OUT_W-1:0] scr_col;
        logic [COLOR_W-1:0]      colour;
        logic                    last;
    } t_fb_write;

    logic i_clk;
    logic i_rst_n;

    pexp_in_if  pix_if ();
    pexp_cfg_if cfg_if ();
    pexp_out_if wr_if ();

    palette_expand_pixel_doubler #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H),
        .PALETTE_DEPTH (PAL_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .i_cfg   (cfg_if),
        .o_wr    (wr_if)
    );

    // Items waiting to go in. The driver presents the head and pops it on
    // acceptance. The writes that accepted pixels must still produce are held
    // in order of arrival.
    t_pix_item items_to_send[$];
    t_fb_write writes_due[$];
    t_fb_write due_write;

    // The bench's view of the block state. Palette slots that were never
    // written are kept out of the pixel stimulus, because their contents are
    // undefined.
    logic [COLOR_W-1:0] palette_copy [PAL_DEPTH];
    int unsigned        src_col;
    int unsigned        tgt_line;
    int unsigned        cur_width;
    int unsigned        cur_height;
    bit                 slot_known [PAL_DEPTH];
    logic [SLOT_W-1:0]  known_slots[$];

    // Idling control. idle_pct sets the chance of a gap or stall burst on
    // either side, and zero turns idling off. The long hold-off is armed once
    // by the stimulus and then timed by a process of its own.
    int idle_pct;
    int gap_left;
    int stall_left;
    bit hold_arm;
    bit hold_used;
    int hold_cycles;

    int mismatches;
    int cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what);
        if (mismatches < REPORT_LIMIT)
            $display("%0t: %s", $time, what);
        mismatches++;
    endtask

    // Work out the writes that one accepted item causes, and update the state.
    // A pixel covers one or two screen lines, and on each line it covers two adjacent
    // columns (doubled), one column (centred) or none (source wider than the screen).
    // A position that falls off the screen is dropped. The last write that survives
    // carries the flag.
    function automatic void expand_item(input t_pix_item it);
        logic [COLOR_W-1:0] raw;
        logic [COLOR_W-1:0] colour;
        int unsigned        lines;
        int unsigned        ln;
        int unsigned        cols[$];
        bit                 hdbl;
        bit                 vdbl;
        t_fb_write          batch[$];
        t_fb_write          w;

        if (it.opcode == OP_PALETTE) begin
            if (it.palette_slot < PAL_DEPTH)
                palette_copy[it.palette_slot] = it.palette_value;
        end else if (it.opcode == OP_FRAME) begin
            src_col  = 0;
            tgt_line = 0;
        end else if (it.opcode == OP_PIXEL) begin
            raw    = (it.pixel_index < PAL_DEPTH) ? palette_copy[it.pixel_index] : '0;
            colour = {raw[7:0], raw[15:8]};
            hdbl   = cur_width * 2 <= SCREEN_W;
            vdbl   = cur_height * 2 <= SCREEN_H;
            lines  = vdbl ? 2 : 1;

            if (hdbl) begin
                cols.push_back(src_col * 2);
                cols.push_back(src_col * 2 + 1);
            end else if (cur_width <= SCREEN_W) begin
                cols.push_back((SCREEN_W - cur_width) / 2 + src_col);
            end

            for (int k = 0; k < lines; k++) begin
                ln = tgt_line + k;
                foreach (cols[c]) begin
                    if (ln < SCREEN_H && cols[c] < SCREEN_W) begin
                        w.scr_line = ln[LINE_OUT_W-1:0];
                        w.scr_col  = cols[c][COLUMN_OUT_W-1:0];
                        w.colour   = colour;
                        w.last     = 1'b0;
                        batch.push_back(w);
                    end
                end
            end

            // At the end of a row the column rewinds and the line moves down by
            // the number of lines that each row takes. A zero width ends a row
            // at every pixel.
            if (src_col + 1 >= cur_width) begin
                src_col  = 0;
                tgt_line = tgt_line + lines;
                if (tgt_line > LINE_CAP)
                    tgt_line = LINE_CAP;
            end else begin
                src_col = (src_col + 1) & 'h1FF;
            end

            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[b])
                writes_due.push_back(batch[b]);
        end
    endfunction

    // Driver: the head of the pending queue is held until it is accepted. Each
    // signal gets a single assignment per edge, so valid stays high across
    // back-to-back items.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
            gap_left     <= 0;
        end else begin
            if (pix_if.valid && pix_if.ready) begin
                expand_item(items_to_send[0]);
                void'(items_to_send.pop_front());
            end

            if (pix_if.valid && !pix_if.ready) begin
                // The block is stalling, so the current item stays on the bus.
            end else if (gap_left > 0) begin
                gap_left     <= gap_left - 1;
                pix_if.valid <= 1'b0;
            end else if (items_to_send.size() > 0) begin
                pix_if.valid         <= 1'b1;
                pix_if.opcode        <= items_to_send[0].opcode;
                pix_if.palette_slot  <= items_to_send[0].palette_slot;
                pix_if.palette_value <= items_to_send[0].palette_value;
                pix_if.pixel_index   <= items_to_send[0].pixel_index;
                if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
                    gap_left <= $urandom_range(1, 4);
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    // Long hold-off on the write side, started once. While it runs the sender
    // keeps offering items. The job queue should fill, and i_pix.ready should
    // fall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cycles <= 0;
            hold_used   <= 1'b0;
        end else if (hold_arm && !hold_used) begin
            hold_cycles <= 200;
            hold_used   <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // Monitor: check each accepted write against the oldest one due, then
    // decide on ready for the next edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wr_if.ready <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (wr_if.valid && wr_if.ready) begin
                if (writes_due.size() == 0) begin
                    flag_mismatch($sformatf(
                        "unexpected write line %0d col %0d colour %h last %0b",
                        wr_if.screen_line, wr_if.screen_column,
                        wr_if.pixel_color, wr_if.last_write));
                end else begin
                    due_write = writes_due.pop_front();
                    if (wr_if.screen_line !== due_write.scr_line ||
                        wr_if.screen_column !== due_write.scr_col ||
                        wr_if.pixel_color !== due_write.colour ||
                        wr_if.last_write !== due_write.last)
                        flag_mismatch($sformatf(
                            "write got %0d/%0d/%h/%0b, expected %0d/%0d/%h/%0b",
                            wr_if.screen_line, wr_if.screen_column,
                            wr_if.pixel_color, wr_if.last_write,
                            due_write.scr_line, due_write.scr_col,
                            due_write.colour, due_write.last));
                end
            end

            if (hold_cycles > 0) begin
                wr_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left  <= stall_left - 1;
                wr_if.ready <= 1'b0;
            end else begin
                wr_if.ready <= 1'b1;
                if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
                    stall_left <= $urandom_range(1, 4);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("palette_expand_pixel_doubler_tb: done, errors");
            $finish;
        end
    end

    // Add an item to the pending queue. A palette write makes its slot
    // available to later pixels.
    task automatic push_item(input logic [OPCODE_W-1:0] op, input logic [SLOT_W-1:0] slot,
                             input logic [COLOR_W-1:0] value,
                             input logic [INDEX_W-1:0] index);
        t_pix_item it;
        it.opcode        = op;
        it.palette_slot  = slot;
        it.palette_value = value;
        it.pixel_index   = index;
        items_to_send.push_back(it);
        if (op == OP_PALETTE && !slot_known[slot]) begin
            slot_known[slot] = 1'b1;
            known_slots.push_back(slot);
        end
    endtask

    // Wait until every item has gone in and every write has come out, then let
    // the pipeline settle. Pixels that land off screen leave nothing to wait for.
    task automatic wait_idle();
        while (items_to_send.size() != 0 || writes_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both size registers back to back while the block is idle. Valid
    // stays high between the two writes.
    task automatic set_registers(input logic [CFG_DATA_W-1:0] width,
                                 input logic [CFG_DATA_W-1:0] height);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= REG_SOURCE_WIDTH;
        cfg_if.data  <= width;
        do @(posedge i_clk); while (!cfg_if.ready);
        cur_width    = 32'(width);
        cfg_if.index <= REG_SOURCE_HEIGHT;
        cfg_if.data  <= height;
        do @(posedge i_clk); while (!cfg_if.ready);
        cur_height   = 32'(height[SRC_HEIGHT_W-1:0]);
        cfg_if.valid <= 1'b0;
    endtask

    // A run of pixels with random known colours, usually opened by a start of
    // frame. Palette writes, unused opcodes and stray frame starts are mixed in
    // as noise.
    task automatic queue_phase(input int pixels, input int noise_pct, input bit open_frame);
        int sent;
        int pick;
        sent = 0;
        @(negedge i_clk);
        if (open_frame)
            push_item(OP_FRAME, SLOT_W'($urandom), COLOR_W'($urandom), INDEX_W'($urandom));
        while (sent < pixels) begin
            pick = $urandom_range(0, 99);
            if (pick < noise_pct / 2) begin
                push_item(OP_PALETTE, SLOT_W'($urandom), COLOR_W'($urandom),
                          INDEX_W'($urandom));
            end else if (pick < noise_pct * 3 / 4) begin
                push_item(OP_UNUSED, SLOT_W'($urandom), COLOR_W'($urandom),
                          INDEX_W'($urandom));
            end else if (pick < noise_pct) begin
                push_item(OP_FRAME, SLOT_W'($urandom), COLOR_W'($urandom),
                          INDEX_W'($urandom));
            end else begin
                push_item(OP_PIXEL, SLOT_W'($urandom), COLOR_W'($urandom),
                          known_slots[$urandom_range(0, known_slots.size() - 1)]);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        pix_if.valid         = 1'b0;
        pix_if.opcode        = OP_FRAME;
        pix_if.palette_slot  = '0;
        pix_if.palette_value = '0;
        pix_if.pixel_index   = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = REG_SOURCE_WIDTH;
        cfg_if.data          = '0;
        wr_if.ready          = 1'b0;
        src_col              = 0;
        tgt_line             = 0;
        cur_width            = 32'(SOURCE_WIDTH_RESET);
        cur_height           = 32'(SOURCE_HEIGHT_RESET);
        idle_pct             = 0;
        hold_arm             = 1'b0;
        mismatches           = 0;
        cycle_count          = 0;
        foreach (slot_known[s])
            slot_known[s] = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, at the reset size of 320 by 240. The row is centred
        // with no offset and there is a single line per row. The palette is
        // filled with the extreme colours and slots first. The pixels then read
        // them back, with an unused opcode, a rewrite of slot 0 and a start of
        // frame in between.
        @(negedge i_clk);
        push_item(OP_PALETTE, 8'h00, 16'hFFFF, 8'h00);
        push_item(OP_PALETTE, 8'hFF, 16'h0000, 8'hFF);
        push_item(OP_PALETTE, 8'hAA, 16'h1234, 8'h00);
        push_item(OP_PALETTE, 8'h55, 16'hA55A, 8'h00);
        push_item(OP_PALETTE, 8'h0F, 16'h00FF, 8'h00);
        push_item(OP_PALETTE, 8'hF0, 16'hFF00, 8'h00);
        push_item(OP_UNUSED,  8'hFF, 16'hFFFF, 8'hFF);
        push_item(OP_PIXEL,   8'h00, 16'h0000, 8'h00);
        push_item(OP_PIXEL,   8'h00, 16'h0000, 8'hFF);
        push_item(OP_PIXEL,   8'h00, 16'h0000, 8'hAA);
        push_item(OP_PIXEL,   8'h00, 16'h0000, 8'h55);
        push_item(OP_PIXEL,   8'h00, 16'h0000, 8'h0F);
        push_item(OP_PIXEL,   8'h00, 16'h0000, 8'hF0);
        push_item(OP_FRAME,   8'h00, 16'h0000, 8'h00);
        push_item(OP_PALETTE, 8'h00, 16'h8001, 8'h00);
        push_item(OP_PIXEL,   8'hFF, 16'hFFFF, 8'h00);
        push_item(OP_PIXEL,   8'h00, 16'h0000, 8'hFF);
        push_item(OP_UNUSED,  8'h00, 16'h0000, 8'h00);

        // Narrow rows doubled both ways give four writes per pixel. The long
        // hold-off on the write side starts during this phase, so the block has
        // to back-pressure its input.
        set_registers(9'd8, 9'd60);
        idle_pct = 30;
        hold_arm = 1'b1;
        queue_phase(30, 12, 1'b1);

        // Widest doubled size, with no idling on either side.
        set_registers(9'd160, 9'd120);
        idle_pct = 0;
        queue_phase(12, 12, 1'b1);

        // One pixel too wide to double, so the row is centred on single lines.
        set_registers(9'd161, 9'd121);
        idle_pct = 40;
        queue_phase(12, 12, 1'b1);

        // Sources wider than the screen give no writes, but the counters still
        // advance.
        set_registers(9'd511, 9'd255);
        idle_pct = 20;
        queue_phase(8, 12, 1'b1);
        set_registers(9'd321, 9'd0);
        queue_phase(6, 12, 1'b1);

        // Zero width with line doubling: every pixel ends its row and moves
        // down two lines. Writes stop once the bottom of the screen is passed.
        // The counter then has to stop at its maximum and not wrap back onto
        // the screen.
        set_registers(9'd0, 9'd0);
        idle_pct = 25;
        queue_phase(262, 0, 1'b1);

        // One-pixel rows take the row end path at every pixel, two-pixel rows at every second.
        set_registers(9'd1, 9'd120);
        idle_pct = 30;
        queue_phase(12, 12, 1'b1);
        set_registers(9'd2, 9'd121);
        idle_pct = 50;
        queue_phase(12, 12, 1'b1);

        // Random sizes: one may be any value at all, and two have widths of no more
        // than 24 pixels.
        set_registers(CFG_DATA_W'($urandom_range(0, 511)), CFG_DATA_W'($urandom_range(0, 255)));
        idle_pct = 20;
        queue_phase(10, 12, $urandom_range(0, 9) != 0);
        repeat (2) begin
            set_registers(CFG_DATA_W'($urandom_range(0, 24)),
                          CFG_DATA_W'($urandom_range(0, 255)));
            queue_phase(10, 12, $urandom_range(0, 9) != 0);
        end

        // Last part: back to the full-size source, with no idling on either side.
        set_registers(SOURCE_WIDTH_RESET, CFG_DATA_W'(SOURCE_HEIGHT_RESET));
        idle_pct = 0;
        queue_phase(10, 8, 1'b1);

        wait_idle();
        if (mismatches == 0)
            $display("palette_expand_pixel_doubler_tb: done, clean");
        else
            $display("palette_expand_pixel_doubler_tb: done, errors");
        $finish;
    end

endmodule

// ===== palette_expand_pixel_doubler.f =====
design/pexp_pkg.sv
design/pexp_in_if.sv
design/pexp_out_if.sv
design/pexp_cfg_if.sv
design/pexp_front.sv
design/pexp_queue.sv
design/pexp_back.sv
design/palette_expand_pixel_doubler.sv
tb/palette_expand_pixel_doubler_tb.sv
